// ===== sv/prewitt_edge_magnitude_defines.svh =====
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude_defines
// assertion macros used by the top-level edge magnitude rtl
// ----------------------------------------------------------------------------
`ifndef PREWITT_EDGE_MAGNITUDE_DEFINES_SVH
`define PREWITT_EDGE_MAGNITUDE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pem_pkg.sv =====
// ----------------------------------------------------------------------------
// pem_pkg
// types and constants for the prewitt edge magnitude block
// ----------------------------------------------------------------------------
`default_nettype none

package pem_pkg;

  localparam int PIX_W         = 8;
  localparam int DIM_W         = 13;
  localparam int ROW_W         = 12;
  localparam int SUM_W         = 10;
  localparam int DIM_LIMIT     = 4096;
  localparam int MIN_DIM       = 3;
  localparam int MAX_WIDTH_DEF = 4096;

  // apb map: one register every 4 bytes
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_B = 2;
  localparam int PDATA_W   = 32;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [ROW_W-1:0] row_t;

  localparam pix_t PIX_MAX    = 8'hFF;
  localparam dim_t WIDTH_RST  = 13'd640;
  localparam dim_t HEIGHT_RST = 13'd480;

  // window rows: 0 top, 2 bottom; columns: 0 oldest, 2 newest
  typedef pix_t [2:0][2:0] pem_win_t;

  // what waits in the window stage
  typedef struct packed {
    logic valid;
    logic last;
  } pem_tag_t;

endpackage

`default_nettype wire

// ===== sv/pem_grad.sv =====
// ----------------------------------------------------------------------------
// pem_grad
// prewitt gradients of the 3x3 window and the output word register
// ----------------------------------------------------------------------------
`default_nettype none

module pem_grad (
  input  logic              clk,
  input  logic              rst_n,
  input  pem_pkg::pem_win_t win,
  input  pem_pkg::pem_tag_t tag,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output pem_pkg::pix_t     out_edge,
  output logic              out_last
);
  import pem_pkg::*;

  function automatic pix_t abs_clamp(input logic [SUM_W-1:0] a, input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] m;
    m = (a >= b) ? (a - b) : (b - a);
    return (m > SUM_W'(PIX_MAX)) ? PIX_MAX : m[PIX_W-1:0];
  endfunction

  logic [SUM_W-1:0] top_sum, bot_sum, lft_sum, rgt_sum;
  pix_t             grad_h, grad_v;
  logic [PIX_W:0]   mag_sum;
  pix_t             edge_val;

  logic out_valid_r;
  pix_t out_edge_r;
  logic out_last_r;

  always_comb begin
    top_sum = SUM_W'(win[0][0]) + SUM_W'(win[0][1]) + SUM_W'(win[0][2]);
    bot_sum = SUM_W'(win[2][0]) + SUM_W'(win[2][1]) + SUM_W'(win[2][2]);
    lft_sum = SUM_W'(win[0][0]) + SUM_W'(win[1][0]) + SUM_W'(win[2][0]);
    rgt_sum = SUM_W'(win[0][2]) + SUM_W'(win[1][2]) + SUM_W'(win[2][2]);
    grad_h  = abs_clamp(bot_sum, top_sum);
    grad_v  = abs_clamp(rgt_sum, lft_sum);
    mag_sum = {1'b0, grad_h} + {1'b0, grad_v};
    edge_val = mag_sum[PIX_W] ? PIX_MAX : mag_sum[PIX_W-1:0];
  end

  // output register frees up when empty or when its word is taken
  assign take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && tag.valid) begin
      out_edge_r <= edge_val;
      out_last_r <= tag.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_edge  = out_edge_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== sv/prewitt_edge_magnitude.sv =====
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude
// streaming 3x3 prewitt edge magnitude over raster-order 8-bit pixels
// ----------------------------------------------------------------------------
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+---------------------------------
//  pixel in  | in  | in_valid / in_ready   | in_pixel_in
//  edge out  | out | out_valid / out_ready | out_edge_out, out_last_of_frame
//  config    | in  | apb psel/penable      | paddr, pwdata, prdata
//
//  one pixel per clock while the output is not stalled; the single line store
//  memory does one read and one write each cycle, which sets that figure
//  an accepted pixel passes the memory read, the window update and the output
//  register, in that order, before its word is shown on out_edge_out
//  rst_n clears counters, window and valid flags; the line store needs no pass
//  a stalled output holds the pipeline; in_ready falls only when all stages
//  are full and the output word is not taken
// ----------------------------------------------------------------------------
`default_nettype none

`include "prewitt_edge_magnitude_defines.svh"

module prewitt_edge_magnitude #(
  parameter int MAX_WIDTH = pem_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pem_pkg::PADDR_W-1:0] paddr,
  input  logic [pem_pkg::PDATA_W-1:0] pwdata,
  output logic [pem_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pem_pkg::pix_t               in_pixel_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pem_pkg::pix_t               out_edge_out,
  output logic                        out_last_of_frame
);
  import pem_pkg::*;

  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW   = (AW > DIM_W) ? AW : DIM_W;
  localparam int WLIM = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
  localparam int LW   = 2 * PIX_W;

  // ---------------- configuration ----------------
  dim_t width_r, height_r;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (paddr[REG_IDX_B])
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[REG_IDX_B])
      REG_WIDTH:  prdata[DIM_W-1:0] = width_r;
      REG_HEIGHT: prdata[DIM_W-1:0] = height_r;
      default:    prdata = '0;
    endcase
  end

  dim_t w_eff, h_eff;

  always_comb begin
    if (width_r < DIM_W'(MIN_DIM)) begin
      w_eff = DIM_W'(MIN_DIM);
    end else if (width_r > DIM_W'(WLIM)) begin
      w_eff = DIM_W'(WLIM);
    end else begin
      w_eff = width_r;
    end
    if (height_r < DIM_W'(MIN_DIM)) begin
      h_eff = DIM_W'(MIN_DIM);
    end else if (height_r > DIM_W'(DIM_LIMIT)) begin
      h_eff = DIM_W'(DIM_LIMIT);
    end else begin
      h_eff = height_r;
    end
  end

  // ---------------- pipeline control ----------------
  logic take, s2_free, s1_fire, in_fire;
  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;

  assign s2_free  = !s2_valid_r || take;
  assign s1_fire  = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // ---------------- counters (accept stage) ----------------
  logic [AW-1:0] col_r, col_nxt;
  row_t          row_r, row_nxt;
  logic [CW-1:0] col_x, row_x, w_x, h_x, c_x, r1_x, r_x, cn_x, rn_x;
  logic [AW-1:0] rd_addr;
  logic          emit, last;

  always_comb begin
    col_x = CW'(col_r);
    row_x = CW'(row_r);
    w_x   = CW'(w_eff);
    h_x   = CW'(h_eff);
    // wrap first when the geometry shrank under the counters
    if (col_x >= w_x) begin
      c_x  = '0;
      r1_x = row_x + CW'(1);
    end else begin
      c_x  = col_x;
      r1_x = row_x;
    end
    r_x  = (r1_x >= h_x) ? '0 : r1_x;
    cn_x = c_x + CW'(1);
    rn_x = r_x + CW'(1);
    if (cn_x >= w_x) begin
      col_nxt = '0;
      row_nxt = (rn_x >= h_x) ? '0 : ROW_W'(rn_x);
    end else begin
      col_nxt = AW'(cn_x);
      row_nxt = ROW_W'(r_x);
    end
    emit    = (r_x >= CW'(2)) && (c_x >= CW'(2));
    last    = (r_x == h_x - CW'(1)) && (c_x == w_x - CW'(1));
    rd_addr = AW'(c_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- line store: {upper, middle} per column ----------------
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] rd_r;
  logic [LW-1:0] wr_data;
  logic [AW-1:0] s1_addr_r;
  pix_t          s1_pix_r;
  logic          s1_emit_r, s1_last_r;

  // upper takes the old middle, middle takes the new pixel
  assign wr_data = {rd_r[PIX_W-1:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (s1_fire && (s1_addr_r == rd_addr)) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= line_mem[rd_addr];
      end
    end
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_fire) begin
      s2_valid_nxt = s1_emit_r;
    end else if (take) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= in_pixel_in;
      s1_addr_r <= rd_addr;
      s1_emit_r <= emit;
      s1_last_r <= last;
    end
  end

  // ---------------- window ----------------
  pem_win_t win_r;
  logic     s2_last_r;
  pem_tag_t s2_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_fire) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= rd_r[LW-1:PIX_W];
      win_r[1][2] <= rd_r[PIX_W-1:0];
      win_r[2][2] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_last_r <= s1_last_r;
    end
  end

  assign s2_tag.valid = s2_valid_r;
  assign s2_tag.last  = s2_last_r;

  pem_grad u_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win_r),
    .tag       (s2_tag),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_edge  (out_edge_out),
    .out_last  (out_last_of_frame)
  );

  // ---------------- checks ----------------
  `PEM_ASSERT_NOW(a_ready_only_when_s1_full, !in_ready, s1_valid_r, "in_ready low with empty stage 1")
  `PEM_ASSERT_NEXT(a_accept_fills_s1, in_fire, s1_valid_r, "accepted word missing from stage 1")
  `PEM_ASSERT_NEXT(a_s1_holds, s1_valid_r && !s1_fire, s1_valid_r && $stable(rd_r) && $stable(s1_pix_r), "stage 1 lost its word under stall")
  `PEM_ASSERT_NEXT(a_s2_holds, s2_valid_r && !take, s2_valid_r && $stable(win_r), "window changed under a pending result")

endmodule

`default_nettype wire
